### design/gdd_pkg.sv
`default_nettype none
// ============================================================================
// gdd_pkg - shared types, constants and calendar tables
// Types and helpers used by the front, queue and back of the date
// difference block.
// ============================================================================
package gdd_pkg;

    localparam int unsigned C_DAY_W   = 5;
    localparam int unsigned C_MONTH_W = 4;
    localparam int unsigned C_YEAR_W  = 14;
    localparam int unsigned C_CENT_W  = 8;   // year / 100 for any 14-bit year
    localparam int unsigned C_DIFF_W  = 22;
    localparam int unsigned C_TAIL_W  = 9;   // days before month + leap + day

    localparam logic [C_YEAR_W-1:0] C_YEAR_MAX = 14'd9999;

    // y / 100 == (y * 5243) >> 19, exact over the whole 14-bit range
    localparam int unsigned         C_DIV100_SHIFT = 19;
    localparam logic [12:0]         C_DIV100_MUL   = 13'd5243;
    localparam int unsigned         C_DIV100_PROD_W = C_YEAR_W + 13;

    localparam logic [C_MONTH_W-1:0] C_MONTH_JAN = 4'd1;
    localparam logic [C_MONTH_W-1:0] C_MONTH_FEB = 4'd2;
    localparam logic [C_MONTH_W-1:0] C_MONTH_DEC = 4'd12;
    localparam logic [C_DAY_W-1:0]   C_FEB_LEAP_DAY = 5'd29;

    localparam logic signed [1:0] C_ORDER_LATER   = 2'sb01;
    localparam logic signed [1:0] C_ORDER_EQUAL   = 2'sb00;
    localparam logic signed [1:0] C_ORDER_EARLIER = 2'sb11;

    localparam int unsigned C_QUEUE_DEPTH = 4;
    localparam int unsigned C_QPTR_W      = $clog2(C_QUEUE_DEPTH);
    localparam int unsigned C_QCNT_W      = $clog2(C_QUEUE_DEPTH + 1);

    // One date after classification in the front
    typedef struct packed {
        logic [C_DAY_W-1:0]   day;
        logic [C_MONTH_W-1:0] month;
        logic [C_YEAR_W-1:0]  year;
        logic [C_CENT_W-1:0]  cent_q;   // year / 100
        logic                 base_ok;  // valid if Feb 29 is allowed
        logic                 feb29;
    } t_date_cls;

    typedef struct packed {
        t_date_cls         first;
        t_date_cls         second;
        logic signed [1:0] order;
    } t_front_item;

    // Longest possible length of each month (Feb taken as 29)
    function automatic logic [C_DAY_W-1:0] month_len(input logic [C_MONTH_W-1:0] m);
        logic [C_DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd29;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of month m
    function automatic logic [C_TAIL_W-1:0] days_before(input logic [C_MONTH_W-1:0] m);
        logic [C_TAIL_W-1:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

### design/gdd_front.sv
`default_nettype none
// ============================================================================
// gdd_front - date classification
// Range checks each date, orders the raw fields and forms year / 100 by
// reciprocal multiply, ready for the queue.
// ============================================================================
module gdd_front (
    input  wire logic [gdd_pkg::C_DAY_W-1:0]   i_first_day,
    input  wire logic [gdd_pkg::C_MONTH_W-1:0] i_first_month,
    input  wire logic [gdd_pkg::C_YEAR_W-1:0]  i_first_year,
    input  wire logic [gdd_pkg::C_DAY_W-1:0]   i_second_day,
    input  wire logic [gdd_pkg::C_MONTH_W-1:0] i_second_month,
    input  wire logic [gdd_pkg::C_YEAR_W-1:0]  i_second_year,
    output gdd_pkg::t_front_item               o_item
);

    function automatic gdd_pkg::t_date_cls classify(
        input logic [gdd_pkg::C_DAY_W-1:0]   d,
        input logic [gdd_pkg::C_MONTH_W-1:0] m,
        input logic [gdd_pkg::C_YEAR_W-1:0]  y
    );
        gdd_pkg::t_date_cls                     c;
        logic [gdd_pkg::C_DIV100_PROD_W-1:0]    prod;
        logic                                   year_ok;
        logic                                   month_ok;
        prod     = gdd_pkg::C_DIV100_PROD_W'(y) *
                   gdd_pkg::C_DIV100_PROD_W'(gdd_pkg::C_DIV100_MUL);
        year_ok  = (y != '0) && (y <= gdd_pkg::C_YEAR_MAX);
        month_ok = (m >= gdd_pkg::C_MONTH_JAN) && (m <= gdd_pkg::C_MONTH_DEC);
        c.day     = d;
        c.month   = m;
        c.year    = y;
        c.cent_q  = prod[gdd_pkg::C_DIV100_SHIFT +: gdd_pkg::C_CENT_W];
        c.base_ok = year_ok && month_ok && (d != '0) && (d <= gdd_pkg::month_len(m));
        c.feb29   = (m == gdd_pkg::C_MONTH_FEB) && (d == gdd_pkg::C_FEB_LEAP_DAY);
        return c;
    endfunction

    logic signed [1:0] order;

    always_comb begin
        priority if (i_first_year != i_second_year) begin
            order = (i_first_year > i_second_year) ? gdd_pkg::C_ORDER_LATER
                                                   : gdd_pkg::C_ORDER_EARLIER;
        end else if (i_first_month != i_second_month) begin
            order = (i_first_month > i_second_month) ? gdd_pkg::C_ORDER_LATER
                                                     : gdd_pkg::C_ORDER_EARLIER;
        end else if (i_first_day != i_second_day) begin
            order = (i_first_day > i_second_day) ? gdd_pkg::C_ORDER_LATER
                                                 : gdd_pkg::C_ORDER_EARLIER;
        end else begin
            order = gdd_pkg::C_ORDER_EQUAL;
        end
    end

    always_comb begin
        o_item.first  = classify(i_first_day, i_first_month, i_first_year);
        o_item.second = classify(i_second_day, i_second_month, i_second_year);
        o_item.order  = order;
    end

endmodule
`default_nettype wire

### design/gdd_queue.sv
`default_nettype none
// ============================================================================
// gdd_queue - classified item queue
// Small flop-based FIFO between the front and the back.
// ============================================================================
module gdd_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire gdd_pkg::t_front_item i_data,
    output logic                      o_full,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output gdd_pkg::t_front_item      o_data
);

    gdd_pkg::t_front_item r_mem [gdd_pkg::C_QUEUE_DEPTH];

    logic [gdd_pkg::C_QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [gdd_pkg::C_QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [gdd_pkg::C_QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == gdd_pkg::C_QCNT_W'(gdd_pkg::C_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + gdd_pkg::C_QCNT_W'(i_push) - gdd_pkg::C_QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != gdd_pkg::C_QCNT_W'(gdd_pkg::C_QUEUE_DEPTH))
        else $error("queue pushed while full");
`endif

endmodule
`default_nettype wire

### design/gdd_back.sv
`default_nettype none
// ============================================================================
// gdd_back - serial day count and difference
// Three-stage pipeline: leap/validity and year base, serial day number,
// absolute difference into the output register.
// ============================================================================
module gdd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire gdd_pkg::t_front_item          i_data,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_first_valid,
    output logic                               o_second_valid,
    output logic signed [1:0]                  o_order,
    output logic [gdd_pkg::C_DIFF_W-1:0]       o_day_difference
);

    typedef struct packed {
        logic                           valid;
        logic [gdd_pkg::C_DIFF_W-1:0]   base;   // 365*p + p/4
        logic [gdd_pkg::C_CENT_W-1:0]   pq;     // p / 100
        logic [gdd_pkg::C_TAIL_W-1:0]   tail;
    } t_s1_date;

    function automatic t_s1_date stage1(input gdd_pkg::t_date_cls c);
        t_s1_date                         r;
        logic [gdd_pkg::C_YEAR_W:0]       hundreds;
        logic                             cent;
        logic                             leap;
        logic [gdd_pkg::C_YEAR_W-1:0]     p;
        hundreds = (gdd_pkg::C_YEAR_W+1)'(c.cent_q) * (gdd_pkg::C_YEAR_W+1)'(100);
        cent     = ({1'b0, c.year} == hundreds);
        leap     = (c.year[1:0] == 2'b00) && (!cent || (c.cent_q[1:0] == 2'b00));
        p        = c.year - 1'b1;
        r.valid  = c.base_ok && (!c.feb29 || leap);
        r.base   = gdd_pkg::C_DIFF_W'(p) * gdd_pkg::C_DIFF_W'(365)
                 + gdd_pkg::C_DIFF_W'(p[gdd_pkg::C_YEAR_W-1:2]);
        // a century year has p/100 one below year/100
        r.pq     = c.cent_q - gdd_pkg::C_CENT_W'(cent);
        r.tail   = gdd_pkg::days_before(c.month)
                 + gdd_pkg::C_TAIL_W'(leap && (c.month > gdd_pkg::C_MONTH_FEB))
                 + gdd_pkg::C_TAIL_W'(c.day);
        return r;
    endfunction

    function automatic logic [gdd_pkg::C_DIFF_W-1:0] serial(input t_s1_date s);
        return s.base - gdd_pkg::C_DIFF_W'(s.pq)
             + gdd_pkg::C_DIFF_W'(s.pq[gdd_pkg::C_CENT_W-1:2])
             + gdd_pkg::C_DIFF_W'(s.tail);
    endfunction

    logic advance;

    logic                         r_s1_vld;
    t_s1_date                     r_s1_a, r_s1_b;
    logic signed [1:0]            r_s1_order;

    logic                         r_s2_vld;
    logic                         r_s2_va, r_s2_vb;
    logic [gdd_pkg::C_DIFF_W-1:0] r_s2_sa, r_s2_sb;
    logic signed [1:0]            r_s2_order;

    logic                         r_out_valid;
    logic                         r_first_valid, r_second_valid;
    logic signed [1:0]            r_order;
    logic [gdd_pkg::C_DIFF_W-1:0] r_diff, n_diff;

    // whole pipeline moves together; stalls only when the output item waits
    assign advance = !r_out_valid || i_out_ready;
    assign o_pop   = advance && !i_empty;

    always_comb begin
        if (!(r_s2_va && r_s2_vb)) begin
            n_diff = '0;
        end else if (r_s2_sa >= r_s2_sb) begin
            n_diff = r_s2_sa - r_s2_sb;
        end else begin
            n_diff = r_s2_sb - r_s2_sa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_vld    <= !i_empty;
            r_s2_vld    <= r_s1_vld;
            r_out_valid <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_a         <= stage1(i_data.first);
            r_s1_b         <= stage1(i_data.second);
            r_s1_order     <= i_data.order;
            r_s2_va        <= r_s1_a.valid;
            r_s2_vb        <= r_s1_b.valid;
            r_s2_sa        <= serial(r_s1_a);
            r_s2_sb        <= serial(r_s1_b);
            r_s2_order     <= r_s1_order;
            r_first_valid  <= r_s2_va;
            r_second_valid <= r_s2_vb;
            r_order        <= r_s2_order;
            r_diff         <= n_diff;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_first_valid    = r_first_valid;
    assign o_second_valid   = r_second_valid;
    assign o_order          = r_order;
    assign o_day_difference = r_diff;

endmodule
`default_nettype wire

### design/gregorian_date_difference.sv
`default_nettype none
// ============================================================================
// gregorian_date_difference - days between two Gregorian dates
// Validates two dates, orders them and gives the absolute day count.
// ============================================================================
// Takes one pair of dates per cycle and sustains one result per cycle
// while the output is not held. An accepted pair goes through the
// four-entry queue behind the classifying front, then two back stages that
// form the serial day numbers, then the output register. While the output
// item waits the back holds, and the queue absorbs up to four more pairs
// before in_ready drops. A date is valid for years 1..9999, months 1..12
// and days 1..month length with Gregorian leap years; the difference is 0
// when either date is invalid, while the order always compares the raw
// year, month and day fields.
module gregorian_date_difference (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [gdd_pkg::C_DAY_W-1:0]   i_first_day,
    input  wire logic [gdd_pkg::C_MONTH_W-1:0] i_first_month,
    input  wire logic [gdd_pkg::C_YEAR_W-1:0]  i_first_year,
    input  wire logic [gdd_pkg::C_DAY_W-1:0]   i_second_day,
    input  wire logic [gdd_pkg::C_MONTH_W-1:0] i_second_month,
    input  wire logic [gdd_pkg::C_YEAR_W-1:0]  i_second_year,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_first_valid,
    output logic                               o_second_valid,
    output logic signed [1:0]                  o_order,
    output logic [gdd_pkg::C_DIFF_W-1:0]       o_day_difference
);

    gdd_pkg::t_front_item front_item;
    gdd_pkg::t_front_item queue_item;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic                 push;

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    gdd_front u_front (
        .i_first_day    (i_first_day),
        .i_first_month  (i_first_month),
        .i_first_year   (i_first_year),
        .i_second_day   (i_second_day),
        .i_second_month (i_second_month),
        .i_second_year  (i_second_year),
        .o_item         (front_item)
    );

    gdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (queue_item)
    );

    gdd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_data           (queue_item),
        .o_pop            (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_first_valid    (o_first_valid),
        .o_second_valid   (o_second_valid),
        .o_order          (o_order),
        .o_day_difference (o_day_difference)
    );

`ifndef SYNTHESIS
    a_invalid_no_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (!o_first_valid || !o_second_valid) |-> o_day_difference == '0)
        else $error("nonzero difference with an invalid date");

    a_equal_no_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_order == gdd_pkg::C_ORDER_EQUAL) |-> o_day_difference == '0)
        else $error("nonzero difference for equal dates");
`endif

endmodule
`default_nettype wire

### tb/tb_gregorian_date_difference.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_gregorian_date_difference - testbench for the date difference block
// Sends pairs of dates through the valid/ready input and checks the
// validity flags, order and day count of every result item against a
// calendar predictor kept here. Directed items cover field extremes, order and
// leap-year rules, then random pairs run under bursty input and output stalls.
// ============================================================================
module tb_gregorian_date_difference;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [gdd_pkg::C_DAY_W-1:0]   day;
        logic [gdd_pkg::C_MONTH_W-1:0] month;
        logic [gdd_pkg::C_YEAR_W-1:0]  year;
    } t_date;

    typedef struct packed {
        logic                          first_ok;
        logic                          second_ok;
        logic signed [1:0]             order;
        logic [gdd_pkg::C_DIFF_W-1:0]  days;
    } t_span_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [gdd_pkg::C_DAY_W-1:0]   i_first_day = '0;
    logic [gdd_pkg::C_MONTH_W-1:0] i_first_month = '0;
    logic [gdd_pkg::C_YEAR_W-1:0]  i_first_year = '0;
    logic [gdd_pkg::C_DAY_W-1:0]   i_second_day = '0;
    logic [gdd_pkg::C_MONTH_W-1:0] i_second_month = '0;
    logic [gdd_pkg::C_YEAR_W-1:0]  i_second_year = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_first_valid;
    logic                          o_second_valid;
    logic signed [1:0]             o_order;
    logic [gdd_pkg::C_DIFF_W-1:0]  o_day_difference;

    t_span_result  pending_spans[$];
    int unsigned   error_count = 0;
    int unsigned   pairs_sent = 0;
    int unsigned   real_pairs = 0;
    int unsigned   spans_checked = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   burst_left = 0;
    int unsigned   stall_left = 0;
    bit            idle_en = 1'b0;
    int unsigned   stall_mode = 0;

    gregorian_date_difference u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_first_day      (i_first_day),
        .i_first_month    (i_first_month),
        .i_first_year     (i_first_year),
        .i_second_day     (i_second_day),
        .i_second_month   (i_second_month),
        .i_second_year    (i_second_year),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_first_valid    (o_first_valid),
        .o_second_valid   (o_second_valid),
        .o_order          (o_order),
        .o_day_difference (o_day_difference)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = leap_year(y) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    function automatic bit real_date(input t_date dt);
        if (dt.year < 1 || dt.year > 9999) return 1'b0;
        if (dt.month < 1 || dt.month > 12) return 1'b0;
        return dt.day >= 1 && dt.day <= month_days(dt.month, dt.year);
    endfunction

    // days since a fixed epoch; meaningful only for real dates
    function automatic int unsigned day_serial(input t_date dt);
        int unsigned yrs;
        int unsigned total;
        yrs = dt.year - 1;
        total = 365 * yrs + yrs / 4 - yrs / 100 + yrs / 400;
        for (int k = 1; k < dt.month; k++)
            total += month_days(k, dt.year);
        return total + dt.day;
    endfunction

    function automatic logic signed [1:0] date_order(input t_date a, input t_date b);
        if (a.year != b.year)
            return (a.year > b.year) ? gdd_pkg::C_ORDER_LATER : gdd_pkg::C_ORDER_EARLIER;
        if (a.month != b.month)
            return (a.month > b.month) ? gdd_pkg::C_ORDER_LATER : gdd_pkg::C_ORDER_EARLIER;
        if (a.day != b.day)
            return (a.day > b.day) ? gdd_pkg::C_ORDER_LATER : gdd_pkg::C_ORDER_EARLIER;
        return gdd_pkg::C_ORDER_EQUAL;
    endfunction

    function automatic t_span_result predict_span(input t_date a, input t_date b);
        t_span_result r;
        int unsigned  sa;
        int unsigned  sb;
        r.first_ok  = real_date(a);
        r.second_ok = real_date(b);
        r.order     = date_order(a, b);
        r.days      = '0;
        if (r.first_ok && r.second_ok) begin
            sa = day_serial(a);
            sb = day_serial(b);
            r.days = gdd_pkg::C_DIFF_W'((sa >= sb) ? sa - sb : sb - sa);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Date generators
    // ------------------------------------------------------------------
    function automatic t_date mk_date(input int unsigned d, input int unsigned m,
                                      input int unsigned y);
        t_date dt;
        dt.day   = gdd_pkg::C_DAY_W'(d);
        dt.month = gdd_pkg::C_MONTH_W'(m);
        dt.year  = gdd_pkg::C_YEAR_W'(y);
        return dt;
    endfunction

    function automatic t_date random_real_date();
        t_date dt;
        dt.year  = gdd_pkg::C_YEAR_W'($urandom_range(1, 9999));
        dt.month = gdd_pkg::C_MONTH_W'($urandom_range(1, 12));
        dt.day   = gdd_pkg::C_DAY_W'($urandom_range(1, month_days(dt.month, dt.year)));
        return dt;
    endfunction

    function automatic t_date raw_date();
        t_date dt;
        dt.day   = gdd_pkg::C_DAY_W'($urandom_range(0, 31));
        dt.month = gdd_pkg::C_MONTH_W'($urandom_range(0, 15));
        dt.year  = gdd_pkg::C_YEAR_W'($urandom_range(0, 16383));
        return dt;
    endfunction

    // small step away from a date; may land on an unreal one
    function automatic t_date nudge_date(input t_date dt);
        t_date n;
        n = dt;
        case ($urandom_range(0, 3))
            0:       n.day   = gdd_pkg::C_DAY_W'(dt.day + $urandom_range(0, 3) - 1);
            1:       n.month = gdd_pkg::C_MONTH_W'(dt.month + $urandom_range(0, 2) - 1);
            2:       n.year  = gdd_pkg::C_YEAR_W'(dt.year + $urandom_range(0, 2) - 1);
            default: n.day   = gdd_pkg::C_DAY_W'($urandom_range(1, 31));
        endcase
        return n;
    endfunction

    // around Feb/Mar of century and quad years, or the Dec 31 before them
    function automatic t_date leap_edge_date();
        int unsigned y;
        case ($urandom_range(0, 11))
            0:       y = 1600;
            1:       y = 1700;
            2:       y = 1900;
            3:       y = 2000;
            4:       y = 2100;
            5:       y = 4;
            6:       y = 100;
            7:       y = 400;
            8:       y = 9600;
            9:       y = 9900;
            10:      y = 9996;
            default: y = $urandom_range(1, 2499) * 4;
        endcase
        case ($urandom_range(0, 3))
            0:       return mk_date(29, 2, y);
            1:       return mk_date(28, 2, y);
            2:       return mk_date(1, 3, y);
            default: return mk_date(31, 12, y - 1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver, checker, watchdog
    // ------------------------------------------------------------------
    task automatic send_pair(input t_date a, input t_date b);
        int unsigned gap;
        if (idle_en && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_first_day    <= a.day;
        i_first_month  <= a.month;
        i_first_year   <= a.year;
        i_second_day   <= b.day;
        i_second_month <= b.month;
        i_second_year  <= b.year;
        do @(posedge i_clk); while (!o_in_ready);
        pending_spans.push_back(predict_span(a, b));
        pairs_sent++;
        if (real_date(a) && real_date(b)) real_pairs++;
    endtask

    // hold the input idle until every outstanding result is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // receiver: mode 0 never stalls, 1 short random stalls, 2 long stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if (stall_mode == 1 && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 3);
            else if (stall_mode == 2 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(4, 12);
        end
    end

    always @(posedge i_clk) begin
        t_span_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_spans.size() == 0) begin
                $display("%0t: unexpected result: first_ok=%0b second_ok=%0b order=%0d days=%0d",
                         $time, o_first_valid, o_second_valid, o_order, o_day_difference);
                error_count++;
            end else begin
                exp_r = pending_spans.pop_front();
                spans_checked++;
                if (o_first_valid !== exp_r.first_ok) begin
                    $display("%0t: first_valid mismatch: expected %0b, actual %0b",
                             $time, exp_r.first_ok, o_first_valid);
                    error_count++;
                end
                if (o_second_valid !== exp_r.second_ok) begin
                    $display("%0t: second_valid mismatch: expected %0b, actual %0b",
                             $time, exp_r.second_ok, o_second_valid);
                    error_count++;
                end
                if (o_order !== exp_r.order) begin
                    $display("%0t: order mismatch: expected %0d, actual %0d",
                             $time, exp_r.order, o_order);
                    error_count++;
                end
                if (o_day_difference !== exp_r.days) begin
                    $display("%0t: day_difference mismatch: expected %0d, actual %0d",
                             $time, exp_r.days, o_day_difference);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_spans.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        send_pair(mk_date(0, 0, 0), mk_date(0, 0, 0));
        send_pair(mk_date(31, 15, 16383), mk_date(31, 15, 16383));
        send_pair(mk_date(0, 15, 0), mk_date(31, 0, 16383));
        send_pair(mk_date(1, 1, 1), mk_date(31, 12, 9999));      // widest span
        send_pair(mk_date(31, 12, 9999), mk_date(1, 1, 1));
        send_pair(mk_date(15, 6, 10000), mk_date(15, 6, 2020));  // year past range
        send_pair(mk_date(10, 13, 2020), mk_date(10, 12, 2020)); // month past range
        wait_drained();
    endtask

    task automatic test_calendar_rules();
        send_pair(mk_date(29, 2, 2000), mk_date(1, 3, 2000));
        send_pair(mk_date(29, 2, 1900), mk_date(28, 2, 1900));   // century, no leap day
        send_pair(mk_date(29, 2, 2004), mk_date(29, 2, 2001));
        send_pair(mk_date(28, 2, 2024), mk_date(1, 3, 2024));
        send_pair(mk_date(31, 11, 2021), mk_date(30, 11, 2021)); // November has 30
        send_pair(mk_date(31, 4, 1999), mk_date(31, 5, 1999));
        send_pair(mk_date(0, 5, 1999), mk_date(1, 5, 1999));     // day zero
        send_pair(mk_date(31, 12, 1999), mk_date(1, 1, 2000));
        wait_drained();
    endtask

    task automatic test_order_and_span();
        send_pair(mk_date(15, 7, 1987), mk_date(15, 7, 1987));
        send_pair(mk_date(1, 1, 2001), mk_date(31, 12, 2000));
        send_pair(mk_date(1, 3, 2010), mk_date(28, 4, 2010));
        send_pair(mk_date(20, 8, 2015), mk_date(19, 8, 2015));
        send_pair(mk_date(2, 8, 2015), mk_date(19, 8, 2015));
        send_pair(mk_date(30, 2, 2015), mk_date(1, 9, 2015));    // order on unreal date
        send_pair(mk_date(1, 1, 1), mk_date(1, 1, 401));
        wait_drained();
    endtask

    task automatic test_random_pairs(input int unsigned count, input bit gaps,
                                     input int unsigned stall_kind);
        t_date       a;
        t_date       b;
        int unsigned pick;
        idle_en    = gaps;
        stall_mode = stall_kind;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            a = random_real_date();
            if (pick < 40) begin
                b = random_real_date();
            end else if (pick < 62) begin
                b = nudge_date(a);
            end else if (pick < 70) begin
                b = a;
            end else if (pick < 84) begin
                a = leap_edge_date();
                b = ($urandom_range(0, 1) == 0) ? leap_edge_date() : nudge_date(a);
            end else if (pick < 92) begin
                b = raw_date();
                if ($urandom_range(0, 1) == 0) {a, b} = {b, a};
            end else begin
                a = raw_date();
                b = raw_date();
            end
            send_pair(a, b);
            if ($urandom_range(0, 149) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_calendar_rules();
        stall_mode = 1;
        test_order_and_span();

        test_random_pairs(450, 1'b1, 1);
        test_random_pairs(420, 1'b0, 0);
        test_random_pairs(420, 1'b1, 0);
        test_random_pairs(440, 1'b0, 2);

        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d date pairs, %0d with both dates real, %0d with an invalid date",
                 pairs_sent, real_pairs, pairs_sent - real_pairs);
        $display("checked %0d results under input gaps and output stalls, %0d errors",
                 spans_checked, error_count);
        if (error_count == 0 && pending_spans.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
